// ----- sv/radix_integer_to_ascii_macros.svh -----
// Assertion macros for the radix integer to ASCII converter.
// Used by the top level; no other dependencies.
`ifndef RADIX_INTEGER_TO_ASCII_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_MACROS_SVH
`ifndef ASSERT_OFF
`define RITOA_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("radix_integer_to_ascii: assertion failed");
`define RITOA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("radix_integer_to_ascii: assertion failed");
`else
`define RITOA_ASSERT_IMPL(label, clk, rst, cond, prop)
`define RITOA_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ----- sv/ritoa_pkg.sv -----
// Shared types, constants and the digit-to-character function for the
// radix integer to ASCII converter. No dependencies.
package ritoa_pkg;

   localparam int MAX_DIGITS = 32;
   localparam int VALUE_W    = 31;
   localparam int RADIX_W    = 6;
   localparam int LIMIT_W    = 6;
   localparam int CHAR_W     = 8;
   localparam int COUNT_OUT_W = 6;
   localparam int STATUS_W   = 2;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int STEP_W     = $clog2(VALUE_W);

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] DECIMAL_SPAN = RADIX_W'(10);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(97);

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RADIX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRUNC     = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] number_in;
      logic [RADIX_W-1:0] radix;
      logic [LIMIT_W-1:0] digit_limit;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0]      ascii_char;
      logic                   last_char;
      logic [COUNT_OUT_W-1:0] digit_count;
      logic [STATUS_W-1:0]    status;
   } rsp_payload_type;

   typedef struct packed {
      logic               go;
      logic [VALUE_W-1:0] dividend;
      logic [RADIX_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [RADIX_W-1:0] remainder;
   } div_res_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] r);
      logic [CHAR_W-1:0] r_ext;
      r_ext = CHAR_W'(r);
      if (r < DECIMAL_SPAN) begin
         return CHAR_ZERO + r_ext;
      end
      return CHAR_A + r_ext - CHAR_W'(DECIMAL_SPAN);
   endfunction

endpackage

// ----- sv/ritoa_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
// Depends on ritoa_pkg.
module ritoa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ritoa_pkg::div_cmd_type cmd,
   output ritoa_pkg::div_res_type res
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ritoa_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [ritoa_pkg::VALUE_W-1:0]   dvd_ff, dvd_in;
   logic [ritoa_pkg::RADIX_W-1:0]   rem_ff, rem_in;
   logic [ritoa_pkg::RADIX_W-1:0]   dvs_ff, dvs_in;
   logic [ritoa_pkg::RADIX_W:0]     partial;
   logic [ritoa_pkg::RADIX_W:0]     diff;
   logic                            fits;

   // Partial remainder picks up the next dividend bit; subtract when it fits.
   assign partial = {rem_ff, dvd_ff[ritoa_pkg::VALUE_W-1]};
   assign fits    = partial >= {1'b0, dvs_ff};
   assign diff    = partial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (cmd.go) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[ritoa_pkg::VALUE_W-2:0], fits};
         rem_in  = fits ? diff[ritoa_pkg::RADIX_W-1:0] : partial[ritoa_pkg::RADIX_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == ritoa_pkg::STEP_W'(ritoa_pkg::VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = dvd_ff;
   assign res.remainder = rem_ff;

endmodule

// ----- sv/radix_integer_to_ascii.sv -----
// Top level of the radix integer to ASCII converter: sequencer, digit store
// and output register. Depends on ritoa_pkg, ritoa_div and the macros header.
`include "radix_integer_to_ascii_macros.svh"

// How to use this block.
// A request is presented on req_data together with start; it is taken at the
// rising edge where start is high and busy is low. Each request carries a
// value, a base and a digit limit. The block answers with one result per
// digit on rsp_data, most significant digit first, each marked by rsp_valid
// for exactly one cycle. The last result of a request has last_char set and
// carries the digit count and the status. A base outside 2 to 36 gives a
// single error result in the cycle after the request, and the block stays
// ready. Otherwise the value is divided by the base in a shared bit-serial
// divider, one digit per division, so the divider sets the rate. The digits
// are then read back from the digit store, each character passing through a
// read state and then an emit state. Busy stays high for the whole request,
// which has up to 31 digits for the widest value in base 2, and its last
// result appears in the cycle in which busy drops. A zero value skips the
// divider and goes straight to reading back its single digit '0'.
// The receiver cannot stall: every result is simply presented for one cycle.
// Reset returns the sequencer to idle and drops any conversion in progress;
// the digit store is not cleared, since each entry is written before it is read.
module radix_integer_to_ascii (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  ritoa_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   output ritoa_pkg::rsp_payload_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [ritoa_pkg::RADIX_W-1:0]   radix_ff, radix_in;
   logic [ritoa_pkg::CNT_W-1:0]     limit_ff, limit_in;
   logic [ritoa_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                            trunc_ff, trunc_in;
   logic [ritoa_pkg::IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ritoa_pkg::RADIX_W-1:0]   rd_data_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   ritoa_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;

   // Digit store, lowest digit at entry zero.
   logic [ritoa_pkg::RADIX_W-1:0]   digit_mem [ritoa_pkg::MAX_DIGITS];
   logic                            wr_en;
   logic [ritoa_pkg::IDX_W-1:0]     wr_addr;
   logic [ritoa_pkg::RADIX_W-1:0]   wr_data;

   ritoa_pkg::div_cmd_type          div_cmd;
   ritoa_pkg::div_res_type          div_res;

   logic                            accept;
   logic                            bad_radix;
   logic [ritoa_pkg::CNT_W-1:0]     req_limit;
   logic [ritoa_pkg::CNT_W-1:0]     count_next;
   logic                            last_digit;
   logic                            err_rsp;

   assign accept    = start && !busy;
   assign bad_radix = (req_data.radix < ritoa_pkg::RADIX_MIN) ||
                      (req_data.radix > ritoa_pkg::RADIX_MAX);
   assign count_next = count_ff + 1'b1;
   assign last_digit = (rd_ptr_ff == '0);

   // A limit of zero counts as one; a limit above the store depth saturates.
   always_comb begin
      if (req_data.digit_limit == '0) begin
         req_limit = ritoa_pkg::CNT_W'(1);
      end else if (int'(req_data.digit_limit) > ritoa_pkg::MAX_DIGITS) begin
         req_limit = ritoa_pkg::CNT_W'(ritoa_pkg::MAX_DIGITS);
      end else begin
         req_limit = ritoa_pkg::CNT_W'(req_data.digit_limit);
      end
   end

   ritoa_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      trunc_in     = trunc_ff;
      rd_ptr_in    = rd_ptr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ritoa_pkg::IDX_W-1:0];
      wr_data      = div_res.remainder;
      div_cmd.go       = 1'b0;
      div_cmd.dividend = req_data.number_in;
      div_cmd.divisor  = req_data.radix;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (bad_radix) begin
                  // Error result goes out next cycle; the block stays ready.
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.ascii_char  = '0;
                  rsp_data_in.last_char   = 1'b1;
                  rsp_data_in.digit_count = '0;
                  rsp_data_in.status      = ritoa_pkg::STATUS_BAD_RADIX;
               end else if (req_data.number_in == '0) begin
                  // Zero has the single digit '0'.
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  wr_data   = '0;
                  count_in  = ritoa_pkg::CNT_W'(1);
                  trunc_in  = 1'b0;
                  rd_ptr_in = '0;
                  state_in  = ST_READ;
               end else begin
                  radix_in   = req_data.radix;
                  limit_in   = req_limit;
                  count_in   = '0;
                  div_cmd.go = 1'b1;
                  state_in   = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               wr_en    = 1'b1;
               count_in = count_next;
               if ((div_res.quotient != '0) && (count_next < limit_ff)) begin
                  div_cmd.go       = 1'b1;
                  div_cmd.dividend = div_res.quotient;
                  div_cmd.divisor  = radix_ff;
               end else begin
                  trunc_in  = (div_res.quotient != '0);
                  rd_ptr_in = count_ff[ritoa_pkg::IDX_W-1:0];
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            // The store's registered read settles during this cycle.
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.ascii_char  = ritoa_pkg::digit_char(rd_data_ff);
            rsp_data_in.last_char   = last_digit;
            rsp_data_in.digit_count = last_digit ?
                                      ritoa_pkg::COUNT_OUT_W'(count_ff) : '0;
            rsp_data_in.status      = (last_digit && trunc_ff) ?
                                      ritoa_pkg::STATUS_TRUNC : ritoa_pkg::STATUS_OK;
            if (last_digit) begin
               state_in = ST_IDLE;
            end else begin
               rd_ptr_in = rd_ptr_ff - 1'b1;
               state_in  = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      radix_ff    <= radix_in;
      limit_ff    <= limit_in;
      count_ff    <= count_in;
      trunc_ff    <= trunc_in;
      rd_ptr_ff   <= rd_ptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= digit_mem[rd_ptr_ff];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A final result that reports a bad base.
   assign err_rsp = rsp_valid && rsp_data.last_char &&
                    (rsp_data.status == ritoa_pkg::STATUS_BAD_RADIX);

   // A request with a bad base answers at once with a final error result.
   `RITOA_ASSERT_NEXT(a_bad_radix_answer, clock, reset, accept && bad_radix, err_rsp)
   // A result that is not the last one means more digits are still on the way.
   `RITOA_ASSERT_IMPL(a_more_follow, clock, reset, rsp_valid && !rsp_data.last_char, busy)
   // Every emit cycle produces exactly one result.
   `RITOA_ASSERT_NEXT(a_emit_strobe, clock, reset, state_ff == ST_EMIT, rsp_valid)
   // The divider only finishes while the sequencer waits for it.
   `RITOA_ASSERT_IMPL(a_div_owner, clock, reset, div_res.done, state_ff == ST_DIV)

endmodule
